// ===== rtl/srbq_pkg.sv =====
package srbq_pkg;

    localparam int RING_SIZE  = 64;
    localparam int RING_AW    = $clog2(RING_SIZE);
    localparam int MEM_DEPTH  = 4 * (2 ** RING_AW);
    localparam int MEM_AW     = RING_AW + 2;

    localparam int ID_W       = 6;
    localparam int CNT_W      = 16;
    localparam int SC_W       = 7;
    localparam int G_W        = SC_W + 1;
    localparam int LEN_W      = 16;
    localparam int OFS_W      = 32;
    localparam int PROD_W     = G_W + LEN_W;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_CLIENT_GET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLIENT_PUT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SERVER_GET = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SERVER_PUT = 2'd3;

    localparam logic [1:0] RING_RECV_AVAIL = 2'd0;
    localparam logic [1:0] RING_SEND_AVAIL = 2'd1;
    localparam logic [1:0] RING_RECV_USED  = 2'd2;
    localparam logic [1:0] RING_SEND_USED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECV_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_COUNT = 2'd3;

    localparam logic [OFS_W-1:0] RST_DATA_START = 32'd32768;
    localparam logic [LEN_W-1:0] RST_SLOT_BYTES = 16'd5120;
    localparam logic [SC_W-1:0]  RST_RECV_COUNT = 7'd64;
    localparam logic [SC_W-1:0]  RST_SEND_COUNT = 7'd64;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic            vld;
        logic            ok;
        logic            found;
        logic            use_mem;
        logic            sel;
        logic [ID_W-1:0] id_pre;
    } t_lookup;

    function automatic logic [ID_W-1:0] slot_to_id(input logic [RING_AW-1:0] slot);
        return ID_W'(slot);
    endfunction

    function automatic logic [RING_AW-1:0] slot_inc(input logic [RING_AW-1:0] slot,
                                                   input logic wrap);
        logic [RING_AW-1:0] res;
        if (wrap || slot == RING_AW'(RING_SIZE - 1)) begin
            res = '0;
        end else begin
            res = slot + 1'b1;
        end
        return res;
    endfunction

    function automatic logic [SC_W-1:0] laid(input logic [SC_W-1:0] cnt);
        return (int'(cnt) < RING_SIZE) ? cnt : SC_W'(RING_SIZE);
    endfunction

endpackage

// ===== rtl/srbq_in_if.sv =====
interface srbq_in_if;
    logic                        valid;
    logic                        ready;
    logic [srbq_pkg::CMD_W-1:0]  cmd;
    logic                        queue_sel;
    logic [srbq_pkg::ID_W-1:0]   desc_id;

    modport source (output valid, cmd, queue_sel, desc_id, input ready);
    modport sink   (input valid, cmd, queue_sel, desc_id, output ready);
endinterface

// ===== rtl/srbq_out_if.sv =====
interface srbq_out_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [srbq_pkg::ID_W-1:0]   got_id;
    logic [srbq_pkg::OFS_W-1:0]  buf_offset;
    logic [srbq_pkg::LEN_W-1:0]  buf_len;

    modport source (output valid, ok, got_id, buf_offset, buf_len, input ready);
    modport sink   (input valid, ok, got_id, buf_offset, buf_len, output ready);
endinterface

// ===== rtl/split_ring_buffer_queue_pair.sv =====
// Receive and send split-ring descriptor queues. All four rings (receive and
// send, available and used) share one synchronous RAM, at most one access per
// command. A command passes three register stages: the ring read at
// acceptance, the descriptor index times buffer size product, and the offset
// add into the output register, from which its result word is shown. One
// command is in flight at a time, so the input takes no new word until the
// result leaves the product stage, and it waits for as long as a finished
// result is held back there. The output register lets the next command enter
// while the previous result still waits. Configuration writes take effect at
// once and belong to idle periods; a send_count write also restarts the count
// of fresh send descriptors.
module split_ring_buffer_queue_pair (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    srbq_in_if.sink                             i_in,
    srbq_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [srbq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [srbq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    srbq_pkg::t_cfg_wr            cfg;
    srbq_pkg::t_lookup            lk;
    logic                         done;
    logic                         mem_we;
    logic                         mem_re;
    logic [srbq_pkg::MEM_AW-1:0]  mem_waddr;
    logic [srbq_pkg::MEM_AW-1:0]  mem_raddr;
    logic [srbq_pkg::ID_W-1:0]    mem_wdata;
    logic [srbq_pkg::ID_W-1:0]    mem_rdata;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    srbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .i_done      (done),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_waddr (mem_waddr),
        .o_mem_raddr (mem_raddr),
        .o_mem_wdata (mem_wdata),
        .o_lk        (lk)
    );

    srbq_ram #(
        .WIDTH (srbq_pkg::ID_W),
        .DEPTH (srbq_pkg::MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    srbq_desc u_desc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_lk    (lk),
        .i_rdata (mem_rdata),
        .o_done  (done),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/srbq_ram.sv =====
module srbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/srbq_ctrl.sv =====
module srbq_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    srbq_in_if.sink                           i_in,
    input  srbq_pkg::t_cfg_wr                 i_cfg,
    input  logic                              i_done,
    output logic                              o_mem_we,
    output logic                              o_mem_re,
    output logic [srbq_pkg::MEM_AW-1:0]       o_mem_waddr,
    output logic [srbq_pkg::MEM_AW-1:0]       o_mem_raddr,
    output logic [srbq_pkg::ID_W-1:0]         o_mem_wdata,
    output srbq_pkg::t_lookup                 o_lk
);

    logic [srbq_pkg::CNT_W-1:0]   r_cnt      [4];
    logic [srbq_pkg::RING_AW-1:0] r_cnt_slot [4];
    logic [srbq_pkg::CNT_W-1:0]   r_pos      [4];
    logic [srbq_pkg::RING_AW-1:0] r_pos_slot [4];
    logic [srbq_pkg::RING_SIZE-1:0] r_written;
    logic [srbq_pkg::SC_W-1:0]    r_fresh_head;
    logic [srbq_pkg::RING_AW-1:0] r_fresh_slot;
    logic [srbq_pkg::SC_W-1:0]    r_fresh_left;
    logic                         r_busy;
    srbq_pkg::t_lookup            r_lk;
    srbq_pkg::t_lookup            n_lk;

    logic                         acc;
    logic                         is_push;
    logic                         is_used;
    logic [1:0]                   ring;
    logic                         fresh;
    logic                         do_pop;
    logic [srbq_pkg::RING_AW-1:0] pos_slot;
    logic [srbq_pkg::RING_AW-1:0] cnt_slot;

    assign i_in.ready = i_rst_n && !r_busy;
    assign acc        = i_in.valid && i_in.ready;

    assign is_push  = (i_in.cmd == srbq_pkg::CMD_CLIENT_PUT) ||
                      (i_in.cmd == srbq_pkg::CMD_SERVER_PUT);
    assign is_used  = (i_in.cmd == srbq_pkg::CMD_CLIENT_GET) ||
                      (i_in.cmd == srbq_pkg::CMD_SERVER_PUT);
    assign ring     = {is_used, i_in.queue_sel};
    assign pos_slot = r_pos_slot[ring];
    assign cnt_slot = r_cnt_slot[ring];
    assign fresh    = (i_in.cmd == srbq_pkg::CMD_CLIENT_GET) && i_in.queue_sel &&
                      (r_fresh_left != '0);
    assign do_pop   = !is_push && !fresh && (r_pos[ring] != r_cnt[ring]);

    assign o_mem_we    = acc && is_push;
    assign o_mem_waddr = {ring, cnt_slot};
    assign o_mem_wdata = i_in.desc_id;
    assign o_mem_re    = acc && do_pop;
    assign o_mem_raddr = {ring, pos_slot};

    always_comb begin
        n_lk.vld     = acc;
        n_lk.ok      = is_push || fresh || do_pop;
        n_lk.found   = fresh || do_pop;
        n_lk.use_mem = do_pop &&
                       !(ring == srbq_pkg::RING_RECV_AVAIL && !r_written[pos_slot]);
        n_lk.sel     = i_in.queue_sel;
        n_lk.id_pre  = fresh ? srbq_pkg::slot_to_id(r_fresh_slot)
                             : srbq_pkg::slot_to_id(pos_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_cnt[k]      <= (k == int'(srbq_pkg::RING_RECV_AVAIL)) ?
                                 srbq_pkg::CNT_W'(srbq_pkg::RING_SIZE) : '0;
                r_cnt_slot[k] <= '0;
                r_pos[k]      <= '0;
                r_pos_slot[k] <= '0;
            end
            r_written    <= '0;
            r_fresh_head <= '0;
            r_fresh_slot <= '0;
            r_fresh_left <= srbq_pkg::RST_SEND_COUNT;
            r_busy       <= 1'b0;
            r_lk         <= '0;
        end else begin
            r_lk <= n_lk;
            if (acc) begin
                r_busy <= 1'b1;
            end else if (i_done) begin
                r_busy <= 1'b0;
            end
            if (acc && is_push) begin
                r_cnt[ring]      <= r_cnt[ring] + 1'b1;
                r_cnt_slot[ring] <= srbq_pkg::slot_inc(cnt_slot, &r_cnt[ring]);
                if (ring == srbq_pkg::RING_RECV_AVAIL) begin
                    r_written[cnt_slot] <= 1'b1;
                end
            end
            if (acc && do_pop) begin
                r_pos[ring]      <= r_pos[ring] + 1'b1;
                r_pos_slot[ring] <= srbq_pkg::slot_inc(pos_slot, &r_pos[ring]);
            end
            if (acc && fresh) begin
                r_fresh_head <= r_fresh_head + 1'b1;
                r_fresh_slot <= srbq_pkg::slot_inc(r_fresh_slot, &r_fresh_head);
            end
            if (i_cfg.we && i_cfg.idx == srbq_pkg::CFG_SEND_COUNT) begin
                r_fresh_left <= i_cfg.data[srbq_pkg::SC_W-1:0];
            end else if (acc && fresh) begin
                r_fresh_left <= r_fresh_left - 1'b1;
            end
        end
    end

    assign o_lk = r_lk;

endmodule

// ===== rtl/srbq_desc.sv =====
module srbq_desc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srbq_pkg::t_cfg_wr             i_cfg,
    input  srbq_pkg::t_lookup             i_lk,
    input  logic [srbq_pkg::ID_W-1:0]     i_rdata,
    output logic                          o_done,
    srbq_out_if.source                    o_out
);

    logic [srbq_pkg::OFS_W-1:0]  r_data_start;
    logic [srbq_pkg::LEN_W-1:0]  r_slot_bytes;
    logic [srbq_pkg::SC_W-1:0]   r_recv_count;
    logic [srbq_pkg::SC_W-1:0]   r_send_count;

    logic                        r_b_vld;
    logic                        r_b_ok;
    logic                        r_b_found;
    logic                        r_b_lay;
    logic [srbq_pkg::ID_W-1:0]   r_b_id;
    logic [srbq_pkg::PROD_W-1:0] r_b_prod;

    logic                        r_out_vld;
    logic                        r_out_ok;
    logic [srbq_pkg::ID_W-1:0]   r_out_id;
    logic [srbq_pkg::OFS_W-1:0]  r_out_ofs;
    logic [srbq_pkg::LEN_W-1:0]  r_out_len;

    logic [srbq_pkg::ID_W-1:0]   id;
    logic [srbq_pkg::SC_W-1:0]   lay_n;
    logic                        lay;
    logic [srbq_pkg::G_W-1:0]    g;
    logic [srbq_pkg::PROD_W-1:0] n_prod;
    logic [srbq_pkg::OFS_W-1:0]  sum;
    logic                        load;
    logic                        show;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start <= srbq_pkg::RST_DATA_START;
            r_slot_bytes <= srbq_pkg::RST_SLOT_BYTES;
            r_recv_count <= srbq_pkg::RST_RECV_COUNT;
            r_send_count <= srbq_pkg::RST_SEND_COUNT;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                srbq_pkg::CFG_DATA_START: r_data_start <= i_cfg.data;
                srbq_pkg::CFG_SLOT_BYTES: r_slot_bytes <= i_cfg.data[srbq_pkg::LEN_W-1:0];
                srbq_pkg::CFG_RECV_COUNT: r_recv_count <= i_cfg.data[srbq_pkg::SC_W-1:0];
                default:                  r_send_count <= i_cfg.data[srbq_pkg::SC_W-1:0];
            endcase
        end
    end

    assign id     = i_lk.use_mem ? i_rdata : i_lk.id_pre;
    assign lay_n  = i_lk.sel ? r_send_count : r_recv_count;
    assign lay    = ({1'b0, id} < lay_n) && (int'(id) < srbq_pkg::RING_SIZE);
    assign g      = i_lk.sel ? srbq_pkg::G_W'(srbq_pkg::laid(r_recv_count)) +
                               srbq_pkg::G_W'(id)
                             : srbq_pkg::G_W'(id);
    assign n_prod = srbq_pkg::PROD_W'(g) * srbq_pkg::PROD_W'(r_slot_bytes);

    assign load   = r_b_vld && (!r_out_vld || o_out.ready);
    assign o_done = load;
    assign sum    = r_data_start + srbq_pkg::OFS_W'(r_b_prod);
    assign show   = r_b_found && r_b_lay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_lk.vld) begin
            r_b_vld <= 1'b1;
        end else if (load) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lk.vld) begin
            r_b_ok    <= i_lk.ok;
            r_b_found <= i_lk.found;
            r_b_lay   <= lay;
            r_b_id    <= id;
            r_b_prod  <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_ok  <= r_b_ok;
            r_out_id  <= r_b_found ? r_b_id : '0;
            r_out_ofs <= show ? sum : '0;
            r_out_len <= show ? r_slot_bytes : '0;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.ok         = r_out_ok;
    assign o_out.got_id     = r_out_id;
    assign o_out.buf_offset = r_out_ofs;
    assign o_out.buf_len    = r_out_len;

endmodule

// ===== rtl/srbq_chk.sv =====
module srbq_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_ok,
    input logic [srbq_pkg::ID_W-1:0]     i_out_got_id,
    input logic [srbq_pkg::OFS_W-1:0]    i_out_buf_offset,
    input logic [srbq_pkg::LEN_W-1:0]    i_out_buf_len
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word shown straight after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a command is in flight");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ok |->
            i_out_got_id == '0 && i_out_buf_offset == '0 && i_out_buf_len == '0)
        else $error("empty get carries a descriptor");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_ok) && $stable(i_out_got_id) &&
            $stable(i_out_buf_offset) && $stable(i_out_buf_len))
        else $error("stalled result word changed");

endmodule

bind split_ring_buffer_queue_pair srbq_chk u_srbq_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_ok         (o_out.ok),
    .i_out_got_id     (o_out.got_id),
    .i_out_buf_offset (o_out.buf_offset),
    .i_out_buf_len    (o_out.buf_len)
);

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srbq_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [ID_W-1:0]    got_id;
        logic [OFS_W-1:0]   buf_offset;
        logic [LEN_W-1:0]   buf_len;
    } t_desc_reply;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic               sel;
        logic [ID_W-1:0]    did;
        bit                 typed;
        t_desc_reply        reply;
    } t_stim_row;

    localparam t_desc_reply NO_DESC   = '0;
    localparam t_desc_reply PUT_DONE  = '{ok: 1'b1, default: '0};
    localparam int          N_ROWS    = 19;
    localparam int          N_PHASES  = 6;
    localparam int          PHASE_LEN = 100;

    t_stim_row directed_rows [N_ROWS] = '{
        '{CMD_CLIENT_GET, 1'b0, 6'd0,  1'b1, NO_DESC},
        '{CMD_SERVER_GET, 1'b1, 6'd0,  1'b1, NO_DESC},
        '{CMD_CLIENT_GET, 1'b1, 6'd0,  1'b1, '{1'b1, 6'd0,  32'd360448, 16'd5120}},
        '{CMD_SERVER_GET, 1'b0, 6'd0,  1'b1, '{1'b1, 6'd0,  32'd32768,  16'd5120}},
        '{CMD_CLIENT_PUT, 1'b0, 6'd63, 1'b1, PUT_DONE},
        '{CMD_CLIENT_PUT, 1'b1, 6'd0,  1'b1, PUT_DONE},
        '{CMD_SERVER_GET, 1'b1, 6'd0,  1'b1, '{1'b1, 6'd0,  32'd360448, 16'd5120}},
        '{CMD_SERVER_PUT, 1'b0, 6'd63, 1'b1, PUT_DONE},
        '{CMD_CLIENT_GET, 1'b0, 6'd0,  1'b1, '{1'b1, 6'd63, 32'd355328, 16'd5120}},
        '{CMD_SERVER_PUT, 1'b1, 6'd63, 1'b1, PUT_DONE},
        '{CMD_CLIENT_GET, 1'b1, 6'd0,  1'b1, '{1'b1, 6'd1,  32'd365568, 16'd5120}},
        '{CMD_SERVER_GET, 1'b0, 6'd63, 1'b0, NO_DESC},
        '{CMD_CLIENT_PUT, 1'b1, 6'd63, 1'b0, NO_DESC},
        '{CMD_SERVER_GET, 1'b1, 6'd0,  1'b0, NO_DESC},
        '{CMD_CLIENT_GET, 1'b0, 6'd63, 1'b0, NO_DESC},
        '{CMD_SERVER_GET, 1'b1, 6'd63, 1'b0, NO_DESC},
        '{CMD_CLIENT_PUT, 1'b0, 6'd0,  1'b0, NO_DESC},
        '{CMD_SERVER_PUT, 1'b1, 6'd0,  1'b0, NO_DESC},
        '{CMD_CLIENT_GET, 1'b1, 6'd0,  1'b0, NO_DESC}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;

    srbq_in_if  in_if ();
    srbq_out_if out_if ();

    split_ring_buffer_queue_pair i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    logic [ID_W-1:0]    ring_mem [4][RING_SIZE];
    logic [CNT_W-1:0]   ring_cnt [4];
    logic [CNT_W-1:0]   ring_pos [4];
    logic [SC_W-1:0]    fresh_head;
    logic [SC_W-1:0]    fresh_left;
    logic [OFS_W-1:0]   data_start;
    logic [LEN_W-1:0]   slot_bytes;
    logic [SC_W-1:0]    recv_count;
    logic [SC_W-1:0]    send_count;

    t_desc_reply        reply_q [$];
    t_desc_reply        want;
    t_desc_reply        seen;
    int                 errors;
    int                 replies_checked;
    int                 empty_gets;
    int                 words_sent;
    int                 settings_done;
    int                 tx_max_gap;
    int                 rx_max_gap;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void reset_model();
        for (int r = 0; r < 4; r++) begin
            for (int i = 0; i < RING_SIZE; i++) begin
                ring_mem[r][i] = '0;
            end
            ring_cnt[r] = '0;
            ring_pos[r] = '0;
        end
        for (int i = 0; i < RING_SIZE; i++) begin
            ring_mem[RING_RECV_AVAIL][i] = ID_W'(i);
        end
        ring_cnt[RING_RECV_AVAIL] = CNT_W'(RING_SIZE);
        data_start = RST_DATA_START;
        slot_bytes = RST_SLOT_BYTES;
        recv_count = RST_RECV_COUNT;
        send_count = RST_SEND_COUNT;
        fresh_head = '0;
        fresh_left = RST_SEND_COUNT;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DATA_START: data_start = data;
            CFG_SLOT_BYTES: slot_bytes = data[LEN_W-1:0];
            CFG_RECV_COUNT: recv_count = data[SC_W-1:0];
            default: begin
                send_count = data[SC_W-1:0];
                fresh_left = data[SC_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [G_W-1:0] laid_descs(logic [SC_W-1:0] cnt);
        return (int'(cnt) < RING_SIZE) ? G_W'(cnt) : G_W'(RING_SIZE);
    endfunction

    function automatic t_desc_reply predict_reply(logic [CMD_W-1:0] cmd, logic sel,
                                                  logic [ID_W-1:0] did);
        t_desc_reply    r;
        logic [1:0]     ring;
        logic           found;
        logic [ID_W-1:0] id;
        logic [G_W-1:0] g;
        r     = '0;
        found = 1'b0;
        id    = '0;
        if (cmd == CMD_CLIENT_GET || cmd == CMD_SERVER_PUT) begin
            ring = sel ? RING_SEND_USED : RING_RECV_USED;
        end else begin
            ring = sel ? RING_SEND_AVAIL : RING_RECV_AVAIL;
        end
        case (cmd)
            CMD_CLIENT_PUT, CMD_SERVER_PUT: begin
                ring_mem[ring][int'(ring_cnt[ring]) % RING_SIZE] = did;
                ring_cnt[ring] = ring_cnt[ring] + 1'b1;
                r.ok = 1'b1;
            end
            default: begin
                if (cmd == CMD_CLIENT_GET && sel && fresh_left != 0) begin
                    fresh_left = fresh_left - 1'b1;
                    id         = ID_W'(int'(fresh_head) % RING_SIZE);
                    fresh_head = fresh_head + 1'b1;
                    found      = 1'b1;
                end else if (ring_pos[ring] != ring_cnt[ring]) begin
                    id             = ring_mem[ring][int'(ring_pos[ring]) % RING_SIZE];
                    ring_pos[ring] = ring_pos[ring] + 1'b1;
                    found          = 1'b1;
                end
            end
        endcase
        if (found) begin
            r.ok     = 1'b1;
            r.got_id = id;
            if (G_W'(id) < (sel ? laid_descs(send_count) : laid_descs(recv_count))) begin
                g            = sel ? laid_descs(recv_count) + G_W'(id) : G_W'(id);
                r.buf_offset = data_start + OFS_W'(g) * OFS_W'(slot_bytes);
                r.buf_len    = slot_bytes;
            end
        end
        return r;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic sel,
                             input logic [ID_W-1:0] did, input t_desc_reply expected);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        reply_q.push_back(expected);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.cmd       <= cmd;
        in_if.queue_sel <= sel;
        in_if.desc_id   <= did;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        words_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [31:0] ds, input logic [31:0] bs,
                                  input logic [31:0] rc, input logic [31:0] sc);
        logic [CFG_IDX_W-1:0]  idx_list [4];
        logic [CFG_DATA_W-1:0] val_list [4];
        idx_list = '{CFG_DATA_START, CFG_SLOT_BYTES, CFG_RECV_COUNT, CFG_SEND_COUNT};
        val_list = '{ds, bs, rc, sc};
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx_list[i];
            cfg_data <= val_list[i];
            apply_register(idx_list[i], val_list[i]);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            seen = '{out_if.ok, out_if.got_id, out_if.buf_offset, out_if.buf_len};
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected reply ok=%0d id=%0d offset=%h len=%0d", $time,
                         seen.ok, seen.got_id, seen.buf_offset, seen.buf_len);
                errors++;
            end else begin
                want = reply_q.pop_front();
                if (seen !== want) begin
                    $display("%0t: reply mismatch: expected ok=%0d id=%0d offset=%h len=%0d,",
                             $time, want.ok, want.got_id, want.buf_offset, want.buf_len);
                    $display("    actual ok=%0d id=%0d offset=%h len=%0d",
                             seen.ok, seen.got_id, seen.buf_offset, seen.buf_len);
                    errors++;
                end
            end
            if (seen.ok === 1'b0) begin
                empty_gets++;
            end
            replies_checked++;
        end
    end

    initial begin
        int  gap;
        bit  held;
        held          = 1'b0;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = $urandom_range(0, rx_max_gap);
            if (!held && replies_checked >= 350) begin
                gap  = 400;
                held = 1'b1;
            end
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_desc_reply      expected;
        logic [CMD_W-1:0] cmd;
        logic             sel;
        logic [ID_W-1:0]  did;
        logic [31:0]      ds, bs, rc, sc;
        int               put_pct;
        int               pick;
        errors          = 0;
        replies_checked = 0;
        empty_gets      = 0;
        words_sent      = 0;
        settings_done   = 0;
        tx_max_gap      = 11;
        rx_max_gap      = 11;
        in_if.valid     <= 1'b0;
        in_if.cmd       <= CMD_CLIENT_GET;
        in_if.queue_sel <= 1'b0;
        in_if.desc_id   <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_DATA_START;
        cfg_data        <= '0;
        i_rst_n         <= 1'b0;
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            expected = predict_reply(directed_rows[i].cmd, directed_rows[i].sel,
                                     directed_rows[i].did);
            if (directed_rows[i].typed) begin
                expected = directed_rows[i].reply;
            end
            send_word(directed_rows[i].cmd, directed_rows[i].sel, directed_rows[i].did,
                      expected);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    ds = 32'hFFFF_FFFF; bs = 32'd65535; rc = 32'd0; sc = 32'd64;
                    put_pct = 50; tx_max_gap = 11; rx_max_gap = 11;
                end
                1: begin
                    ds = 32'd0; bs = 32'd1; rc = 32'd64; sc = 32'd64;
                    put_pct = 50; tx_max_gap = 0; rx_max_gap = 0;
                end
                2: begin
                    ds = $urandom(); bs = $urandom_range(1, 65535);
                    rc = $urandom_range(0, 64); sc = $urandom_range(0, 8);
                    put_pct = 75; tx_max_gap = 11; rx_max_gap = 0;
                end
                3: begin
                    ds = $urandom(); bs = $urandom_range(1, 65535);
                    rc = $urandom_range(1, 63); sc = 32'd64;
                    put_pct = 25; tx_max_gap = 0; rx_max_gap = 11;
                end
                4: begin
                    ds = $urandom(); bs = 32'd65535; rc = 32'd64; sc = 32'd64;
                    put_pct = 50; tx_max_gap = 11; rx_max_gap = 11;
                end
                default: begin
                    ds = RST_DATA_START; bs = RST_SLOT_BYTES; rc = 32'd37; sc = 32'd0;
                    put_pct = 50; tx_max_gap = 3; rx_max_gap = 3;
                end
            endcase
            write_settings(ds, bs, rc, sc);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if ($urandom_range(0, 99) < put_pct) begin
                    cmd = $urandom_range(0, 1) ? CMD_SERVER_PUT : CMD_CLIENT_PUT;
                end else begin
                    cmd = $urandom_range(0, 1) ? CMD_SERVER_GET : CMD_CLIENT_GET;
                end
                sel  = $urandom_range(0, 1);
                pick = $urandom_range(0, 7);
                did  = (pick == 0) ? ID_W'(0) : (pick == 1) ? ID_W'(63)
                                              : ID_W'($urandom_range(0, 63));
                expected = predict_reply(cmd, sel, did);
                send_word(cmd, sel, did, expected);
            end
        end

        drain();
        $display("Covered %0d command words (%0d directed) under %0d register settings;",
                 words_sent, N_ROWS, settings_done + 1);
        $display("%0d replies checked, %0d of them empty gets.", replies_checked, empty_gets);
        if (errors == 0 && reply_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
